// ===== hw/rtl/crrc_pkg.sv =====
// ----------------------------------------------------------------------------
// crrc_pkg
// Shared types and constants for the chunk read reply checker.
// ----------------------------------------------------------------------------
package crrc_pkg;

    localparam int unsigned DATA_HDR_LEN = 20;
    localparam int unsigned STATUS_LEN   = 9;

    // register indexes
    localparam logic [2:0] REG_CHUNK_ID  = 3'd0;
    localparam logic [2:0] REG_START_OFF = 3'd1;
    localparam logic [2:0] REG_READ_LEN  = 3'd2;
    localparam logic [2:0] REG_STATUS    = 3'd3;
    localparam logic [2:0] REG_DATA      = 3'd4;
    localparam logic [2:0] REG_NOP       = 3'd5;
    localparam logic [2:0] REG_UNK_CMD   = 3'd6;
    localparam logic [2:0] REG_BAD_SIZE  = 3'd7;

    typedef enum logic [3:0] {
        OC_RUNNING    = 4'd0,
        OC_OK         = 4'd1,
        OC_BAD_LEN    = 4'd2,
        OC_SRV_STATUS = 4'd3,
        OC_CHUNK      = 4'd4,
        OC_DATA_LEFT  = 4'd5,
        OC_EMPTY_BLK  = 4'd6,
        OC_BLK_NUM    = 4'd7,
        OC_BLK_OFF    = 4'd8,
        OC_BLK_SIZE   = 4'd9,
        OC_CRC        = 4'd10,
        OC_REJECT     = 4'd11,
        OC_UNKNOWN    = 4'd12
    } t_outcome;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       block_last;
        logic [3:0] outcome;
    } t_out_word;

    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] data;
    } t_cfg_word;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/crrc_if.sv =====
// ----------------------------------------------------------------------------
// crrc_if
// Valid/ready channels, each carrying one input, result or register word.
// ----------------------------------------------------------------------------
interface crrc_in_if;
    logic                valid;
    logic                ready;
    crrc_pkg::t_in_word  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface crrc_out_if;
    logic                valid;
    logic                ready;
    crrc_pkg::t_out_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface crrc_cfg_if;
    logic                valid;
    logic                ready;
    crrc_pkg::t_cfg_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/chunk_read_reply_checker.sv =====
// ----------------------------------------------------------------------------
// chunk_read_reply_checker
// Checks the reply byte stream of one chunk read and passes payload through.
// ----------------------------------------------------------------------------
// One word per cycle in while results are taken, one result word per input
// word out, registered and valid in the cycle after its input is taken. Each
// byte updates the header shifter, the compares and a byte-wide CRC-32 step
// combinationally; the result register refills when empty or being taken.
module chunk_read_reply_checker #(
    parameter int unsigned BLOCK_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    crrc_in_if.sink             i_in,
    crrc_out_if.source          o_out,
    crrc_cfg_if.sink            i_cfg
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_HDR, PH_STATUS, PH_DHDR, PH_PAYLOAD, PH_DONE
    } t_phase;

    localparam logic [32:0] BLOCK_SIZE = 33'd1 << BLOCK_BITS;

    logic [63:0] r_chunk_id;
    logic [31:0] r_start_off, r_read_len, r_status, r_data, r_nop, r_unk, r_bad;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_cmd, n_cmd, r_mlen, n_mlen;
    logic [63:0] r_shift, n_shift;
    logic [31:0] r_bsize, n_bsize, r_bcrc, n_bcrc, r_crc, n_crc;
    logic [31:0] r_pleft, n_pleft, r_coff, n_coff, r_bleft, n_bleft;
    logic [3:0]  r_final, n_final;

    logic                r_ovalid;
    crrc_pkg::t_out_word r_out, n_out;

    logic in_take;
    assign i_in.ready    = !r_ovalid || o_out.ready;
    assign in_take       = i_in.valid && i_in.ready;
    assign o_out.valid   = r_ovalid;
    assign o_out.payload = r_out;
    assign i_cfg.ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_id <= '0; r_start_off <= '0; r_read_len <= '0; r_status <= '0;
            r_data <= '0; r_nop <= '0; r_unk <= '0; r_bad <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.index)
                crrc_pkg::REG_CHUNK_ID:  r_chunk_id  <= i_cfg.payload.data;
                crrc_pkg::REG_START_OFF: r_start_off <= i_cfg.payload.data[31:0];
                crrc_pkg::REG_READ_LEN:  r_read_len  <= i_cfg.payload.data[31:0];
                crrc_pkg::REG_STATUS:    r_status    <= i_cfg.payload.data[31:0];
                crrc_pkg::REG_DATA:      r_data      <= i_cfg.payload.data[31:0];
                crrc_pkg::REG_NOP:       r_nop       <= i_cfg.payload.data[31:0];
                crrc_pkg::REG_UNK_CMD:   r_unk       <= i_cfg.payload.data[31:0];
                crrc_pkg::REG_BAD_SIZE:  r_bad       <= i_cfg.payload.data[31:0];
                default: ;
            endcase
        end
    end

    logic [7:0]  b;
    logic [63:0] shift8;
    logic [31:0] hcmd, hlen, crc_nxt, pleft_dec, blk_off, blk_num, breq;
    logic [32:0] brem;

    always_comb begin
        b       = i_in.payload.rx_byte;
        shift8  = {r_shift[55:0], b};
        hcmd    = shift8[63:32];
        hlen    = shift8[31:0];
        crc_nxt = crrc_pkg::crc_byte(r_crc, b);
        pleft_dec = r_pleft - 32'd1;
        blk_num = {16'd0, r_cmd[31:16]};
        blk_off = {16'd0, r_cmd[15:0]};
        brem    = BLOCK_SIZE - {17'd0, r_cmd[15:0]};
        breq    = ({1'b0, r_bleft} < brem) ? r_bleft : brem[31:0];

        n_phase = r_phase; n_cnt = r_cnt; n_cmd = r_cmd; n_mlen = r_mlen;
        n_shift = r_shift; n_bsize = r_bsize; n_bcrc = r_bcrc; n_crc = r_crc;
        n_pleft = r_pleft; n_coff = r_coff; n_bleft = r_bleft; n_final = r_final;
        n_out = '0;

        if (!i_in.payload.mode) begin
            n_coff = r_start_off; n_bleft = r_read_len; n_phase = PH_HDR;
            n_cnt = '0; n_shift = '0; n_final = crrc_pkg::OC_RUNNING;
        end else begin
            unique case (r_phase)
                PH_HDR: begin
                    n_shift = shift8;
                    n_cnt   = r_cnt + 5'd1;
                    if (r_cnt == 5'd7) begin
                        n_cmd = hcmd; n_mlen = hlen; n_cnt = '0;
                        n_out.outcome = crrc_pkg::OC_RUNNING;
                        priority if (hcmd == r_status) begin
                            if (hlen != 32'(crrc_pkg::STATUS_LEN))
                                n_out.outcome = crrc_pkg::OC_BAD_LEN;
                            else n_phase = PH_STATUS;
                        end else if (hcmd == r_data) begin
                            if (hlen < 32'(crrc_pkg::DATA_HDR_LEN))
                                n_out.outcome = crrc_pkg::OC_BAD_LEN;
                            else n_phase = PH_DHDR;
                        end else if (hcmd == r_nop) begin
                            if (hlen != 32'd0) n_out.outcome = crrc_pkg::OC_BAD_LEN;
                        end else if (hcmd == r_unk || hcmd == r_bad) begin
                            n_out.outcome = crrc_pkg::OC_REJECT;
                        end else begin
                            n_out.outcome = crrc_pkg::OC_UNKNOWN;
                        end
                        if (n_out.outcome != crrc_pkg::OC_RUNNING) begin
                            n_phase = PH_DONE; n_final = n_out.outcome;
                        end
                    end
                end
                PH_STATUS: begin
                    n_cnt = r_cnt + 5'd1;
                    if (r_cnt < 5'(crrc_pkg::STATUS_LEN - 1)) begin
                        n_shift = shift8;
                    end else begin
                        priority if (b != 8'd0) n_out.outcome = crrc_pkg::OC_SRV_STATUS;
                        else if (r_shift != r_chunk_id) n_out.outcome = crrc_pkg::OC_CHUNK;
                        else if (r_bleft != 32'd0) n_out.outcome = crrc_pkg::OC_DATA_LEFT;
                        else n_out.outcome = crrc_pkg::OC_OK;
                        n_phase = PH_DONE; n_final = n_out.outcome;
                    end
                end
                PH_DHDR: begin
                    if (r_cnt < 5'd8)       n_shift = shift8;
                    else if (r_cnt < 5'd12) n_cmd   = {r_cmd[23:0], b};
                    else if (r_cnt < 5'd16) n_bsize = {r_bsize[23:0], b};
                    else                    n_bcrc  = {r_bcrc[23:0], b};
                    n_cnt = r_cnt + 5'd1;
                    if (r_cnt == 5'(crrc_pkg::DATA_HDR_LEN - 1)) begin
                        // block number/offset fields and size are complete here
                        priority if (r_shift != r_chunk_id)
                            n_out.outcome = crrc_pkg::OC_CHUNK;
                        else if (r_mlen != 32'(crrc_pkg::DATA_HDR_LEN) + r_bsize)
                            n_out.outcome = crrc_pkg::OC_BAD_LEN;
                        else if (r_bsize == 32'd0)
                            n_out.outcome = crrc_pkg::OC_EMPTY_BLK;
                        else if (blk_num != (r_coff >> BLOCK_BITS))
                            n_out.outcome = crrc_pkg::OC_BLK_NUM;
                        else if (blk_off != (r_coff & (BLOCK_SIZE[31:0] - 32'd1)))
                            n_out.outcome = crrc_pkg::OC_BLK_OFF;
                        else if (r_bsize != breq)
                            n_out.outcome = crrc_pkg::OC_BLK_SIZE;
                        else
                            n_out.outcome = crrc_pkg::OC_RUNNING;
                        if (n_out.outcome != crrc_pkg::OC_RUNNING) begin
                            n_phase = PH_DONE; n_final = n_out.outcome;
                        end else begin
                            n_pleft = r_bsize; n_crc = '1; n_cnt = '0;
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_out.payload_valid = 1'b1;
                    n_out.payload_byte  = b;
                    n_crc   = crc_nxt;
                    n_pleft = pleft_dec;
                    if (pleft_dec == 32'd0) begin
                        n_out.block_last = 1'b1;
                        if (~crc_nxt != r_bcrc) begin
                            n_out.outcome = crrc_pkg::OC_CRC;
                            n_phase = PH_DONE; n_final = crrc_pkg::OC_CRC;
                        end else begin
                            n_coff = r_coff + r_bsize; n_bleft = r_bleft - r_bsize;
                            n_phase = PH_HDR; n_cnt = '0; n_shift = '0;
                        end
                    end
                end
                PH_DONE: n_out.outcome = r_final;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_cnt <= '0; r_cmd <= '0; r_mlen <= '0; r_shift <= '0;
            r_bsize <= '0; r_bcrc <= '0; r_crc <= '0; r_pleft <= '0; r_coff <= '0;
            r_bleft <= '0; r_final <= '0; r_ovalid <= 1'b0;
        end else begin
            if (in_take) begin
                r_phase <= n_phase; r_cnt <= n_cnt; r_cmd <= n_cmd; r_mlen <= n_mlen;
                r_shift <= n_shift; r_bsize <= n_bsize; r_bcrc <= n_bcrc;
                r_crc <= n_crc; r_pleft <= n_pleft; r_coff <= n_coff;
                r_bleft <= n_bleft; r_final <= n_final;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.block_last |-> r_out.payload_valid)
        else $error("block_last without payload");
    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_out.ready |=> r_ovalid && $stable(r_out))
        else $error("result changed while stalled");
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE && !(in_take && !i_in.payload.mode) |=> r_phase == PH_DONE)
        else $error("left done without start");
    a_final_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_phase == PH_DONE) |-> r_final != 4'(crrc_pkg::OC_RUNNING))
        else $error("done with running outcome");
`endif

endmodule

// ===== tb/sv/crrc_reply_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crrc_reply_scoreboard
// Watches the input, result and register channels of the reply checker,
// predicts every result word from its own model of the read state and
// compares each taken result word against the oldest prediction.
// ----------------------------------------------------------------------------
module crrc_reply_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    crrc_in_if   i_in,
    crrc_out_if  i_out,
    crrc_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);

    localparam int unsigned BLK_BITS = 16;
    localparam logic [31:0] BLK_SIZE = 32'd1 << BLK_BITS;
    localparam logic [31:0] BLK_MASK = BLK_SIZE - 32'd1;

    typedef enum logic [2:0] {
        RD_IDLE, RD_HDR, RD_STATUS, RD_BLKHDR, RD_PAYLOAD, RD_DONE
    } t_rd_phase;

    // register copies
    logic [63:0] chunk_id;
    logic [31:0] start_off, read_len, status_cmd, data_cmd, nop_cmd, unk_cmd, bad_cmd;

    // read state
    t_rd_phase   rd_phase;
    logic [4:0]  nbytes;
    logic [31:0] cmd_word, msg_len;
    logic [63:0] shreg;
    logic [31:0] blk_size, blk_crc, crc_acc, pay_left, cur_off, left;
    crrc_pkg::t_outcome final_oc;

    crrc_pkg::t_out_word expected_q[$];

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic fb;
        for (int j = 0; j < 8; j++) begin
            fb = c[0] ^ b[j];
            c  = c >> 1;
            if (fb) c = c ^ 32'hEDB88320;
        end
        return c;
    endfunction

    function automatic crrc_pkg::t_outcome end_read(input crrc_pkg::t_outcome oc);
        final_oc = oc;
        rd_phase = RD_DONE;
        return oc;
    endfunction

    function automatic crrc_pkg::t_outcome decode_header();
        cmd_word = shreg[63:32];
        msg_len  = shreg[31:0];
        nbytes   = '0;
        if (cmd_word == status_cmd) begin
            if (msg_len != crrc_pkg::STATUS_LEN) return end_read(crrc_pkg::OC_BAD_LEN);
            rd_phase = RD_STATUS;
        end else if (cmd_word == data_cmd) begin
            if (msg_len < crrc_pkg::DATA_HDR_LEN) return end_read(crrc_pkg::OC_BAD_LEN);
            rd_phase = RD_BLKHDR;
        end else if (cmd_word == nop_cmd) begin
            if (msg_len != 0) return end_read(crrc_pkg::OC_BAD_LEN);
        end else if (cmd_word == unk_cmd || cmd_word == bad_cmd) begin
            return end_read(crrc_pkg::OC_REJECT);
        end else begin
            return end_read(crrc_pkg::OC_UNKNOWN);
        end
        return crrc_pkg::OC_RUNNING;
    endfunction

    function automatic crrc_pkg::t_outcome check_block_header();
        logic [31:0] bno, boff, breq;
        bno  = {16'd0, cmd_word[31:16]};
        boff = {16'd0, cmd_word[15:0]};
        if (shreg != chunk_id) return end_read(crrc_pkg::OC_CHUNK);
        if (msg_len != crrc_pkg::DATA_HDR_LEN + blk_size)
            return end_read(crrc_pkg::OC_BAD_LEN);
        if (blk_size == 0) return end_read(crrc_pkg::OC_EMPTY_BLK);
        if (bno != (cur_off >> BLK_BITS)) return end_read(crrc_pkg::OC_BLK_NUM);
        if (boff != (cur_off & BLK_MASK)) return end_read(crrc_pkg::OC_BLK_OFF);
        breq = BLK_SIZE - boff;
        if (left < breq) breq = left;
        if (blk_size != breq) return end_read(crrc_pkg::OC_BLK_SIZE);
        pay_left = blk_size;
        crc_acc  = '1;
        nbytes   = '0;
        rd_phase = RD_PAYLOAD;
        return crrc_pkg::OC_RUNNING;
    endfunction

    function automatic crrc_pkg::t_out_word predict_word(input crrc_pkg::t_in_word w);
        crrc_pkg::t_out_word r;
        logic [7:0] b;
        r = '0;
        b = w.rx_byte;
        if (!w.mode) begin
            cur_off  = start_off;
            left     = read_len;
            rd_phase = RD_HDR;
            nbytes   = '0;
            shreg    = '0;
            final_oc = crrc_pkg::OC_RUNNING;
            return r;
        end
        case (rd_phase)
            RD_HDR: begin
                shreg  = {shreg[55:0], b};
                nbytes = nbytes + 1;
                if (nbytes >= 8) r.outcome = decode_header();
            end
            RD_STATUS: begin
                nbytes = nbytes + 1;
                if (nbytes < crrc_pkg::STATUS_LEN) shreg = {shreg[55:0], b};
                else if (b != 0) r.outcome = end_read(crrc_pkg::OC_SRV_STATUS);
                else if (shreg != chunk_id) r.outcome = end_read(crrc_pkg::OC_CHUNK);
                else if (left != 0) r.outcome = end_read(crrc_pkg::OC_DATA_LEFT);
                else r.outcome = end_read(crrc_pkg::OC_OK);
            end
            RD_BLKHDR: begin
                if (nbytes < 8) shreg = {shreg[55:0], b};
                else if (nbytes < 12) cmd_word = {cmd_word[23:0], b};
                else if (nbytes < 16) blk_size = {blk_size[23:0], b};
                else blk_crc = {blk_crc[23:0], b};
                nbytes = nbytes + 1;
                if (nbytes >= crrc_pkg::DATA_HDR_LEN) r.outcome = check_block_header();
            end
            RD_PAYLOAD: begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                crc_acc  = crc_step(crc_acc, b);
                pay_left = pay_left - 1;
                if (pay_left == 0) begin
                    r.block_last = 1'b1;
                    if (~crc_acc != blk_crc) begin
                        r.outcome = end_read(crrc_pkg::OC_CRC);
                    end else begin
                        cur_off  = cur_off + blk_size;
                        left     = left - blk_size;
                        rd_phase = RD_HDR;
                        nbytes   = '0;
                        shreg    = '0;
                    end
                end
            end
            RD_DONE: r.outcome = final_oc;
            default: ;
        endcase
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        crrc_pkg::t_out_word exp_w, act_w;
        crrc_pkg::t_cfg_word c;
        if (!i_rst_n) begin
            {chunk_id, start_off, read_len, status_cmd} <= '0;
            {data_cmd, nop_cmd, unk_cmd, bad_cmd} <= '0;
            rd_phase  <= RD_IDLE;
            nbytes    <= '0;
            {cmd_word, msg_len, shreg} <= '0;
            {blk_size, blk_crc, crc_acc, pay_left, cur_off, left} <= '0;
            final_oc  <= crrc_pkg::OC_RUNNING;
            o_errors  <= 0;
            o_checked <= 0;
            expected_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                act_w = i_out.payload;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, act_w);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = expected_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (act_w.payload_valid !== exp_w.payload_valid ||
                        act_w.payload_byte !== exp_w.payload_byte ||
                        act_w.block_last !== exp_w.block_last ||
                        act_w.outcome !== exp_w.outcome) begin
                        $display({"%0t: result mismatch: expected v=%b b=%h last=%b oc=%0d,",
                                  " actual v=%b b=%h last=%b oc=%0d"},
                                 $time, exp_w.payload_valid, exp_w.payload_byte,
                                 exp_w.block_last, exp_w.outcome, act_w.payload_valid,
                                 act_w.payload_byte, act_w.block_last, act_w.outcome);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                c = i_cfg.payload;
                case (c.index)
                    crrc_pkg::REG_CHUNK_ID:  chunk_id   = c.data;
                    crrc_pkg::REG_START_OFF: start_off  = c.data[31:0];
                    crrc_pkg::REG_READ_LEN:  read_len   = c.data[31:0];
                    crrc_pkg::REG_STATUS:    status_cmd = c.data[31:0];
                    crrc_pkg::REG_DATA:      data_cmd   = c.data[31:0];
                    crrc_pkg::REG_NOP:       nop_cmd    = c.data[31:0];
                    crrc_pkg::REG_UNK_CMD:   unk_cmd    = c.data[31:0];
                    crrc_pkg::REG_BAD_SIZE:  bad_cmd    = c.data[31:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) expected_q.push_back(predict_word(i_in.payload));
        end
    end

endmodule

// ===== tb/sv/chunk_read_reply_checker_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunk_read_reply_checker_test
// Drives reply byte streams for chunk reads into the checker: a few directed
// reads, then random reads with bad messages and random corruption mixed in,
// mostly under random idling on both sides. The scoreboard checks every result.
// ----------------------------------------------------------------------------
module chunk_read_reply_checker_test;

    localparam int ITEM_TARGET = 1600;
    localparam int CYCLE_LIMIT = 600000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, checked;
    int   cycles, words_sent, reads_sent;
    bit   idle_on;

    logic [63:0] r_chunk;
    logic [31:0] r_off, r_len, r_status, r_data, r_nop, r_unk, r_bad;

    bit [8:0] stream_q[$];   // {mode, byte}

    crrc_in_if  in_ch();
    crrc_out_if out_ch();
    crrc_cfg_if cfg_ch();

    chunk_read_reply_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    crrc_reply_scoreboard scoreboard (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        out_ch.ready <= idle_on ? ($urandom_range(0, 99) >= 35) : 1'b1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("chunk_read_reply_checker_test: done, errors");
            $finish;
        end
    end

    function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
        c = c ^ {24'd0, b};
        repeat (8) c = (c >> 1) ^ (c[0] ? 32'hEDB88320 : 32'd0);
        return c;
    endfunction

    task automatic put_word(input crrc_pkg::t_in_word w);
        while (idle_on && $urandom_range(0, 99) < 35) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
        if (!w.mode) reads_sent++;
        idle_on = !(words_sent > 600 && words_sent < 900);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        while (idle_on && $urandom_range(0, 99) < 35) begin
            cfg_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= {idx, value};
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    // hold off until the block is drained, then load all registers
    task automatic load_regs();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        write_reg(crrc_pkg::REG_CHUNK_ID, r_chunk);
        write_reg(crrc_pkg::REG_START_OFF, {32'd0, r_off});
        write_reg(crrc_pkg::REG_READ_LEN, {32'd0, r_len});
        write_reg(crrc_pkg::REG_STATUS, {32'd0, r_status});
        write_reg(crrc_pkg::REG_DATA, {32'd0, r_data});
        write_reg(crrc_pkg::REG_NOP, {32'd0, r_nop});
        write_reg(crrc_pkg::REG_UNK_CMD, {32'd0, r_unk});
        write_reg(crrc_pkg::REG_BAD_SIZE, {32'd0, r_bad});
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_bytes(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) stream_q.push_back({1'b1, v[8*i +: 8]});
    endtask

    task automatic push_msg_hdr(input logic [31:0] cmd, input logic [31:0] len);
        push_bytes({cmd, len}, 8);
    endtask

    task automatic send_stream();
        while (stream_q.size() != 0) put_word(stream_q.pop_front());
    endtask

    task automatic pick_regs();
        int sel;
        sel = $urandom_range(0, 9);
        r_chunk  = {$urandom, $urandom};
        r_status = $urandom;
        r_data   = $urandom;
        r_nop    = $urandom;
        r_unk    = $urandom;
        r_bad    = $urandom;
        if (sel == 0) begin
            r_chunk = '1;
            {r_status, r_data, r_nop, r_unk, r_bad} = {32'hFFFFFFFF, 32'hFFFFFFFE,
                32'hFFFFFFFD, 32'hFFFFFFFC, 32'hFFFFFFFB};
        end else if (sel == 1) begin
            r_chunk = '0;
            r_status = 32'd0;
            r_data   = 32'd1;
            r_nop    = 32'd2;
            {r_unk, r_bad} = {32'd3, 32'd3};
        end else if (sel == 2) begin
            // equal codes: priority order decides
            {r_data, r_nop, r_unk, r_bad} = {4{r_status}};
        end
        sel = $urandom_range(0, 9);
        if (sel < 5) r_off = {16'($urandom_range(0, 65535)),
                              16'hFFFF - 16'($urandom_range(0, 40))};
        else if (sel < 8) r_off = $urandom;
        else if (sel == 8) r_off = 32'hFFFFFFFF;
        else r_off = 32'd0;
        sel = $urandom_range(0, 19);
        if (sel < 14) r_len = $urandom_range(0, 60);
        else if (sel < 18) r_len = $urandom_range(61, 300);
        else if (sel == 18) r_len = 32'hFFFFFFFF;
        else r_len = $urandom;
    endtask

    // one read: start, data blocks (with NOPs), closing status, then damage
    task automatic build_read();
        logic [31:0] cur, left, bsz, crc;
        logic [7:0]  pb;
        int budget, pos, sel;
        stream_q.delete();
        stream_q.push_back({1'b0, 8'($urandom)});
        cur = r_off;
        left = r_len;
        budget = 200;
        while (left != 0 && budget > 0) begin
            if ($urandom_range(0, 5) == 0) push_msg_hdr(r_nop, 32'd0);
            sel = $urandom_range(0, 39);
            if (sel == 0) begin
                push_msg_hdr(r_unk, $urandom);
                break;
            end else if (sel == 1) begin
                push_msg_hdr(r_bad, $urandom);
                break;
            end else if (sel == 2) begin
                push_msg_hdr($urandom, $urandom);
                break;
            end else if (sel == 3) begin
                // empty block
                push_msg_hdr(r_data, crrc_pkg::DATA_HDR_LEN);
                push_bytes(r_chunk, 8);
                push_bytes({32'd0, cur[31:16], cur[15:0]}, 4);
                push_bytes(64'd0, 8);
                break;
            end
            bsz = 32'h10000 - {16'd0, cur[15:0]};
            if (left < bsz) bsz = left;
            push_msg_hdr(r_data, crrc_pkg::DATA_HDR_LEN + bsz);
            push_bytes(r_chunk, 8);
            push_bytes({32'd0, cur[31:16], cur[15:0]}, 4);
            push_bytes({32'd0, bsz}, 4);
            if (bsz > budget) break;
            crc = '1;
            pos = stream_q.size();
            push_bytes(64'd0, 4);
            for (int i = 0; i < bsz; i++) begin
                pb = $urandom;
                crc = crc_update(crc, pb);
                stream_q.push_back({1'b1, pb});
            end
            crc = ~crc;
            for (int i = 0; i < 4; i++) stream_q[pos + i] = {1'b1, crc[8*(3-i) +: 8]};
            budget -= bsz;
            cur = cur + bsz;
            left = left - bsz;
        end
        push_msg_hdr(r_status, crrc_pkg::STATUS_LEN);
        push_bytes(r_chunk, 8);
        stream_q.push_back({1'b1, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd0});
        sel = $urandom_range(0, 19);
        if (sel < 5) begin
            pos = $urandom_range(1, stream_q.size() - 1);
            stream_q[pos][7:0] = stream_q[pos][7:0] ^ 8'($urandom_range(1, 255));
        end else if (sel == 5) begin
            pos = $urandom_range(1, stream_q.size() - 1);
            stream_q[pos][8] = 1'b0;   // restart mid-stream
        end else if (sel == 6) begin
            pos = $urandom_range(1, stream_q.size() - 1);
            stream_q = stream_q[0:pos];
        end
        repeat ($urandom_range(0, 3)) stream_q.push_back({1'b1, 8'($urandom)});
    endtask

    initial begin
        cycles = 0;
        words_sent = 0;
        reads_sent = 0;
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: bytes while idle, empty read closed at once, unknown message
        put_word({1'b1, 8'hFF});
        put_word({1'b1, 8'h00});
        r_chunk = 64'h0123456789ABCDEF;
        {r_off, r_len} = {32'd0, 32'd0};
        {r_status, r_data, r_nop, r_unk, r_bad} = {32'd1, 32'd2, 32'd3, 32'd4, 32'd5};
        load_regs();
        stream_q.delete();
        stream_q.push_back({1'b0, 8'h00});
        push_msg_hdr(r_nop, 32'd0);
        push_msg_hdr(r_status, crrc_pkg::STATUS_LEN);
        push_bytes(r_chunk, 8);
        stream_q.push_back({1'b1, 8'h00});
        stream_q.push_back({1'b1, 8'h5A});
        stream_q.push_back({1'b0, 8'hFF});
        push_msg_hdr(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_stream();

        while (words_sent < ITEM_TARGET) begin
            if (reads_sent % 6 == 0 || $urandom_range(0, 3) == 0) begin
                pick_regs();
                load_regs();
            end
            build_read();
            send_stream();
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d reads, %0d input words, %0d result words checked",
                 reads_sent, words_sent, checked);
        if (errors == 0) begin
            $display("chunk_read_reply_checker_test: done, clean");
        end else begin
            $display("%0d errors", errors);
            $display("chunk_read_reply_checker_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/crrc_pkg.sv
hw/rtl/crrc_if.sv
hw/rtl/chunk_read_reply_checker.sv
tb/sv/crrc_reply_scoreboard.sv
tb/sv/chunk_read_reply_checker_test.sv
